// File: src/blk2s_pkg.sv
package blk2s_pkg;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } out_t;

  localparam logic [1:0] CMD_MSG    = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [1:0] REG_DIGEST_LEN = 2'd0;
  localparam logic [1:0] REG_KEY_LEN    = 2'd1;

  localparam logic [5:0] MAX_DIGEST = 6'd32;
  localparam logic [5:0] MAX_KEY    = 6'd32;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  // Message schedule: nibble for position 0 stands in the top of each row.
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
    logic [63:0] row;
    logic [63:0] sh;
    case (rnd)
      4'd0: row = 64'h0123456789ABCDEF;
      4'd1: row = 64'hEA489FD61C02B753;
      4'd2: row = 64'hB8C052FDAE367194;
      4'd3: row = 64'h7931DCBE265A40F8;
      4'd4: row = 64'h905724AFE1BC683D;
      4'd5: row = 64'h2C6A0B834D75FE19;
      4'd6: row = 64'hC51FED4A0763928B;
      4'd7: row = 64'hDB7EC13950F4862A;
      4'd8: row = 64'h6FE9B308C2D714A5;
      4'd9: row = 64'hA2847615FB9E3CD0;
      default: row = 64'h0123456789ABCDEF;
    endcase
    sh = row >> {4'd15 - pos, 2'b00};
    return sh[3:0];
  endfunction

endpackage

// File: src/blk2s_g_half.sv
module blk2s_g_half (
  input  logic        half,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] m,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);
  import blk2s_pkg::*;

  logic [31:0] dx;
  logic [31:0] bx;

  // One half of G: first half rotates by 16 and 12, second by 8 and 7.
  always_comb begin
    a_out = a + b + m;
    dx    = d ^ a_out;
    d_out = half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
    c_out = c + d_out;
    bx    = b ^ c_out;
    b_out = half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
  end

endmodule

// File: src/blake2s_hash_stream_core.sv
// BLAKE2s byte-stream hash engine.
// Input channel (in_valid/in_ready/in_data) carries one word per item: a
// message byte, a key byte or a finish command. Output channel
// (out_valid/out_ready/out_data) returns the digest one byte per word, the
// final byte flagged by last_byte.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0
// sets the digest length, index 1 the key length; a write to either one
// restarts the run. Write it only while the engine is idle.
// A message or key byte that does not close a block is stored, and the
// engine stays ready. A byte arriving after a full block first runs the
// compression on the shared half-G unit (10 rounds x 8 G x 2 halves) and
// a fold step; the engine is then ready again and the held byte opens the
// next block. Finish runs the same compression and fold, then sends the
// digest one byte per cycle while out_ready is high.
// in_ready is low while compressing and while the digest is being sent.
// A stalled receiver simply holds the current digest byte on the port.
// Reset (rst, synchronous) sets a 32-byte unkeyed digest and an empty run.
module blake2s_hash_stream_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  blk2s_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output blk2s_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [5:0]       cfg_data
);
  import blk2s_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  digest_len;
  logic [5:0]  key_len;
  logic [5:0]  digest_len_next;
  logic [5:0]  key_len_next;
  logic [31:0] h [8];
  logic [31:0] v [16];
  logic [31:0] v_next [16];
  logic [31:0] msg [16];
  logic [63:0] byte_counter;
  logic [63:0] counter_next;
  logic [6:0]  fill_count;
  logic [5:0]  key_taken;
  logic        key_open;
  logic        final_blk;
  logic [7:0]  pend_byte;
  logic [3:0]  rnd;
  logic [2:0]  gi;
  logic        half;
  logic [4:0]  out_idx;
  logic        do_start;
  logic        in_acc;
  logic        out_last;
  logic        mix_done;
  logic [31:0] m_word;
  logic [31:0] ga;
  logic [31:0] gb;
  logic [31:0] gc;
  logic [31:0] gd;
  logic [31:0] vt [16];
  logic [1:0]  amt [4];
  logic [31:0] out_word;
  logic [5:0]  cfg_clamp;

  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign out_word  = h[out_idx[4:2]];
  assign out_last  = ({1'b0, out_idx} + 6'd1) == digest_len;
  assign out_data.digest_byte = 8'(out_word >> {out_idx[1:0], 3'b000});
  assign out_data.last_byte   = out_last;
  assign mix_done  = (rnd == 4'd9) && (gi == 3'd7) && half;
  assign m_word    = msg[sigma(rnd, {gi, half})];

  // Clamp register writes; a write to index 0 or 1 restarts the run.
  always_comb begin
    digest_len_next = digest_len;
    key_len_next    = key_len;
    cfg_clamp       = cfg_data;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIGEST_LEN: begin
          if (cfg_clamp == 6'd0) cfg_clamp = 6'd1;
          digest_len_next = (cfg_clamp > MAX_DIGEST) ? MAX_DIGEST : cfg_clamp;
        end
        REG_KEY_LEN: key_len_next = (cfg_clamp > MAX_KEY) ? MAX_KEY : cfg_clamp;
        default: ;
      endcase
    end
    if (rst) begin
      digest_len_next = MAX_DIGEST;
      key_len_next    = 6'd0;
    end
  end

  assign do_start = rst || (cfg_we && (cfg_index == REG_DIGEST_LEN ||
                    cfg_index == REG_KEY_LEN)) ||
                    (state == ST_OUT && out_ready && out_last);

  // Counter after this block: a full block before a new byte, or the fill on finish.
  assign counter_next = byte_counter +
                        ((in_data.cmd == CMD_FINISH) ? {57'd0, fill_count} : 64'd64);

  blk2s_g_half u_g (
    .half  (half),
    .a     (v[0]),
    .b     (v[4]),
    .c     (v[8]),
    .d     (v[12]),
    .m     (m_word),
    .a_out (ga),
    .b_out (gb),
    .c_out (gc),
    .d_out (gd)
  );

  // G always works on column 0 of the rows; rotate rows after the second
  // half to bring the next lane into place, diagonalising after the fourth
  // G and restoring the layout after the eighth.
  always_comb begin
    for (int i = 0; i < 16; i++) vt[i] = v[i];
    vt[0]  = ga;
    vt[4]  = gb;
    vt[8]  = gc;
    vt[12] = gd;
    for (int k = 0; k < 4; k++) begin
      if (gi == 3'd3)      amt[k] = 2'(1 + k);
      else if (gi == 3'd7) amt[k] = 2'(1 - k);
      else                 amt[k] = 2'd1;
    end
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (half) v_next[4*k+j] = vt[4*k + int'(2'(2'(j) + amt[k]))];
        else      v_next[4*k+j] = vt[4*k+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      digest_len <= digest_len_next;
      key_len    <= key_len_next;
      for (int i = 1; i < 8; i++) h[i] <= IV[i];
      h[0] <= IV[0] ^ {8'd1, 8'd1, 2'b00, key_len_next, 2'b00, digest_len_next};
      byte_counter <= 64'd0;
      for (int i = 0; i < 16; i++) msg[i] <= 32'd0;
      key_taken  <= 6'd0;
      key_open   <= (key_len_next != 6'd0);
      fill_count <= (key_len_next != 6'd0) ? 7'd64 : 7'd0;
      state      <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data.cmd)
              CMD_KEY: begin
                if (key_open && key_taken < key_len) begin
                  msg[key_taken[5:2]][{key_taken[1:0], 3'b000} +: 8] <= in_data.data_byte;
                  key_taken <= key_taken + 6'd1;
                end
              end
              CMD_MSG: begin
                key_open <= 1'b0;
                if (fill_count[6]) begin
                  // Full block pending: compress it, hold the byte for later.
                  pend_byte <= in_data.data_byte;
                  final_blk <= 1'b0;
                  state     <= ST_MIX;
                end else begin
                  msg[fill_count[5:2]][{fill_count[1:0], 3'b000} +: 8] <= in_data.data_byte;
                  fill_count <= fill_count + 7'd1;
                end
              end
              CMD_FINISH: begin
                key_open  <= 1'b0;
                final_blk <= 1'b1;
                state     <= ST_MIX;
              end
              default: ;
            endcase
            if (in_data.cmd == CMD_MSG && fill_count[6] || in_data.cmd == CMD_FINISH) begin
              byte_counter <= counter_next;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              for (int i = 0; i < 4; i++) v[8+i] <= IV[i];
              v[12] <= IV[4] ^ counter_next[31:0];
              v[13] <= IV[5] ^ counter_next[63:32];
              v[14] <= IV[6] ^ {32{in_data.cmd == CMD_FINISH}};
              v[15] <= IV[7];
              rnd   <= 4'd0;
              gi    <= 3'd0;
              half  <= 1'b0;
            end
          end
        end
        ST_MIX: begin
          for (int i = 0; i < 16; i++) v[i] <= v_next[i];
          half <= ~half;
          if (half) begin
            gi <= gi + 3'd1;
            if (gi == 3'd7) rnd <= rnd + 4'd1;
          end
          if (mix_done) state <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[8+i];
          for (int i = 1; i < 16; i++) msg[i] <= 32'd0;
          if (final_blk) begin
            msg[0]  <= 32'd0;
            out_idx <= 5'd0;
            state   <= ST_OUT;
          end else begin
            // Drop the old block; the held byte opens the next one.
            msg[0]     <= {24'd0, pend_byte};
            fill_count <= 7'd1;
            state      <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) out_idx <= out_idx + 5'd1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
